>>> design/red_pkg.sv
// package for the rotary encoder step decoder: payload types, codes and constants
`default_nettype none
package red_pkg;

    localparam int NUM_REGS   = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;
    localparam int MAX_RES    = 3;

    localparam logic [7:0] RISING_CODE = 8'd4;
    localparam logic [7:0] BUTTON_BASE = 8'd138;

    typedef enum logic [2:0] {
        REG_IN_MODULE    = 3'd0,
        REG_DEV_A        = 3'd1,
        REG_DEV_B        = 3'd2,
        REG_DEV_C        = 3'd3,
        REG_SPEED_RELOAD = 3'd4,
        REG_OUT_MODULE   = 3'd5,
        REG_OUT_ADDR     = 3'd6
    } reg_idx_t;

    typedef enum logic [2:0] {
        EDGE_A_UP   = 3'd0,
        EDGE_A_DOWN = 3'd1,
        EDGE_B_UP   = 3'd2,
        EDGE_B_DOWN = 3'd3,
        EDGE_NONE   = 3'd4
    } edge_t;

    typedef enum logic [1:0] {
        KIND_LEFT   = 2'd0,
        KIND_RIGHT  = 2'd1,
        KIND_BUTTON = 2'd2
    } kind_t;

    typedef struct packed {
        logic       op;
        logic [7:0] module_req;
        logic [7:0] device;
        logic [7:0] event_code;
    } in_item_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] target_module;
        logic [7:0] target_device;
        logic [7:0] speed_value;
        logic [7:0] button_command;
        logic       last;
    } out_item_t;

    typedef struct packed {
        logic [7:0] in_module;
        logic [7:0] dev_a;
        logic [7:0] dev_b;
        logic [7:0] dev_c;
        logic [7:0] speed_reload;
        logic [7:0] out_module;
        logic [7:0] out_addr;
    } cfg_t;

    typedef struct packed {
        out_item_t [MAX_RES-1:0] slot;
        logic [1:0]              count;
    } res_set_t;

endpackage
`default_nettype wire

>>> design/red_cfg_regs.sv
// configuration register file of the rotary encoder step decoder
`default_nettype none
module red_cfg_regs (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [red_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [red_pkg::CFG_DATA_W-1:0]  cfg_data,
    output red_pkg::cfg_t                        cfg
);

    red_pkg::cfg_t cfg_reg;
    red_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (red_pkg::reg_idx_t'(cfg_index))
                red_pkg::REG_IN_MODULE:    cfg_next.in_module    = cfg_data;
                red_pkg::REG_DEV_A:        cfg_next.dev_a        = cfg_data;
                red_pkg::REG_DEV_B:        cfg_next.dev_b        = cfg_data;
                red_pkg::REG_DEV_C:        cfg_next.dev_c        = cfg_data;
                red_pkg::REG_SPEED_RELOAD: cfg_next.speed_reload = cfg_data;
                red_pkg::REG_OUT_MODULE:   cfg_next.out_module   = cfg_data;
                red_pkg::REG_OUT_ADDR:     cfg_next.out_addr     = cfg_data;
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.in_module    <= 8'd0;
            cfg_reg.dev_a        <= 8'd0;
            cfg_reg.dev_b        <= 8'd1;
            cfg_reg.dev_c        <= 8'd2;
            cfg_reg.speed_reload <= 8'd0;
            cfg_reg.out_module   <= 8'd0;
            cfg_reg.out_addr     <= 8'd0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

>>> design/red_decode.sv
// decode of one transaction: step detection, button code and next encoder state
`default_nettype none
module red_decode (
    input  wire red_pkg::in_item_t item,
    input  wire red_pkg::cfg_t     cfg,
    input  wire red_pkg::edge_t    last_edge,
    input  wire logic [7:0]        speed_count,
    output red_pkg::edge_t         last_edge_next,
    output logic [7:0]             speed_count_next,
    output red_pkg::res_set_t      res
);

    logic           match;
    logic           rising;
    logic           hit_a;
    logic           hit_b;
    logic           hit_c;
    logic           step_a;
    logic           step_b;
    red_pkg::edge_t edge_1;
    red_pkg::edge_t edge_2;
    logic [7:0]     speed_1;
    logic [7:0]     speed_2;
    red_pkg::out_item_t res_a;
    red_pkg::out_item_t res_b;
    red_pkg::out_item_t res_c;

    assign match  = !item.op && (item.module_req == cfg.in_module);
    assign rising = (item.event_code == red_pkg::RISING_CODE);

    // contact a
    assign hit_a   = match && (item.device == cfg.dev_a);
    assign step_a  = hit_a && (rising ? (last_edge == red_pkg::EDGE_B_UP)
                                      : (last_edge == red_pkg::EDGE_B_DOWN));
    assign edge_1  = hit_a ? (rising ? red_pkg::EDGE_A_UP : red_pkg::EDGE_A_DOWN) : last_edge;
    assign speed_1 = step_a ? cfg.speed_reload : speed_count;

    // contact b, sees the state left by contact a
    assign hit_b   = match && (item.device == cfg.dev_b);
    assign step_b  = hit_b && (rising ? (edge_1 == red_pkg::EDGE_A_UP)
                                      : (edge_1 == red_pkg::EDGE_A_DOWN));
    assign edge_2  = hit_b ? (rising ? red_pkg::EDGE_B_UP : red_pkg::EDGE_B_DOWN) : edge_1;
    assign speed_2 = step_b ? cfg.speed_reload : speed_1;

    // push contact
    assign hit_c = match && (item.device == cfg.dev_c);

    always_comb
    begin
        res_a.kind           = red_pkg::KIND_LEFT;
        res_a.target_module  = cfg.out_module;
        res_a.target_device  = cfg.out_addr;
        res_a.speed_value    = speed_count;
        res_a.button_command = 8'd0;
        res_a.last           = !step_b && !hit_c;

        res_b.kind           = red_pkg::KIND_RIGHT;
        res_b.target_module  = cfg.out_module;
        res_b.target_device  = cfg.out_addr;
        res_b.speed_value    = speed_1;
        res_b.button_command = 8'd0;
        res_b.last           = !hit_c;

        res_c.kind           = red_pkg::KIND_BUTTON;
        res_c.target_module  = cfg.out_module;
        res_c.target_device  = cfg.out_addr;
        res_c.speed_value    = 8'd0;
        res_c.button_command = {6'd0, item.event_code[3:2]} + red_pkg::BUTTON_BASE;
        res_c.last           = 1'b1;
    end

    // pack results in order a, b, c
    always_comb
    begin
        res = '0;
        if (step_a)
        begin
            res.slot[res.count] = res_a;
            res.count           = res.count + 2'd1;
        end
        if (step_b)
        begin
            res.slot[res.count] = res_b;
            res.count           = res.count + 2'd1;
        end
        if (hit_c)
        begin
            res.slot[res.count] = res_c;
            res.count           = res.count + 2'd1;
        end
    end

    always_comb
    begin
        if (item.op)
        begin
            last_edge_next   = last_edge;
            speed_count_next = (speed_count != 8'd0) ? speed_count - 8'd1 : 8'd0;
        end
        else
        begin
            last_edge_next   = edge_2;
            speed_count_next = speed_2;
        end
    end

endmodule
`default_nettype wire

>>> design/red_result_buf.sv
// result buffer holding the results of one transaction and sending them one per cycle while result_stall is low
`default_nettype none
module red_result_buf (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load,
    input  wire red_pkg::res_set_t res,
    output logic                   free,
    output logic                   result_valid,
    input  wire logic              result_stall,
    output red_pkg::out_item_t     result
);

    red_pkg::out_item_t [red_pkg::MAX_RES-1:0] slot_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic [1:0] idx_reg;
    logic [1:0] idx_next;
    logic       take;

    assign result_valid = (idx_reg != count_reg);
    assign take         = result_valid && !result_stall;
    assign free         = !result_valid || (take && (idx_reg + 2'd1 == count_reg));
    assign result       = result_valid ? slot_reg[idx_reg] : '0;

    always_comb
    begin
        count_next = count_reg;
        idx_next   = idx_reg;
        if (load)
        begin
            count_next = res.count;
            idx_next   = 2'd0;
        end
        else if (take)
        begin
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
            idx_reg   <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            slot_reg <= res.slot;
        end
    end

endmodule
`default_nettype wire

>>> design/rotary_encoder_step_decoder.sv
// top level of the rotary encoder step decoder
//
// channel   direction  handshake                    payload
// item      in         item_valid / item_stall      red_pkg::in_item_t
// result    out        result_valid / result_stall  red_pkg::out_item_t
// cfg       in         cfg_we                       cfg_index, cfg_data
//
// a transaction passes the input register and the result buffer before its results
// one transaction per cycle when each causes at most one result and result_stall is
// low; a transaction with several results holds the buffer, one result per cycle
// reset sets last edge to none, speed counter to zero and the registers to defaults
// item_stall rises only while the input register waits on a full result buffer
`default_nettype none
module rotary_encoder_step_decoder (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           item_valid,
    output logic                                item_stall,
    input  wire red_pkg::in_item_t              item,
    output logic                                result_valid,
    input  wire logic                           result_stall,
    output red_pkg::out_item_t                  result,
    input  wire logic                           cfg_we,
    input  wire logic [red_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [red_pkg::CFG_DATA_W-1:0] cfg_data
);

    red_pkg::cfg_t     cfg;
    red_pkg::in_item_t item_reg;
    logic              item_valid_reg;
    logic              item_valid_next;
    red_pkg::edge_t    last_edge_reg;
    red_pkg::edge_t    last_edge_next;
    logic [7:0]        speed_count_reg;
    logic [7:0]        speed_count_next;
    red_pkg::res_set_t res;
    logic              buf_free;
    logic              move;
    logic              accept;

    red_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    red_decode u_decode (
        .item             (item_reg),
        .cfg              (cfg),
        .last_edge        (last_edge_reg),
        .speed_count      (speed_count_reg),
        .last_edge_next   (last_edge_next),
        .speed_count_next (speed_count_next),
        .res              (res)
    );

    red_result_buf u_buf (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (move),
        .res          (res),
        .free         (buf_free),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    assign move       = item_valid_reg && buf_free;
    assign item_stall = item_valid_reg && !buf_free;
    assign accept     = item_valid && !item_stall;

    always_comb
    begin
        if (accept)
        begin
            item_valid_next = 1'b1;
        end
        else if (move)
        begin
            item_valid_next = 1'b0;
        end
        else
        begin
            item_valid_next = item_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg  <= 1'b0;
            last_edge_reg   <= red_pkg::EDGE_NONE;
            speed_count_reg <= 8'd0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            if (move)
            begin
                last_edge_reg   <= last_edge_next;
                speed_count_reg <= speed_count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item;
        end
    end

endmodule
`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// testbench for the rotary encoder step decoder: step and button predictor, stimulus and checks
import red_pkg::*;

class red_scoreboard;
    cfg_t        regs;
    edge_t       last_seen;
    logic [7:0]  speed_cnt;
    out_item_t   expected_results[$];
    int          errors;

    function new();
        regs.in_module    = 8'd0;
        regs.dev_a        = 8'd0;
        regs.dev_b        = 8'd1;
        regs.dev_c        = 8'd2;
        regs.speed_reload = 8'd0;
        regs.out_module   = 8'd0;
        regs.out_addr     = 8'd0;
        last_seen         = EDGE_NONE;
        speed_cnt         = 8'd0;
        errors            = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [7:0] val);
        case (idx)
            REG_IN_MODULE:    regs.in_module = val;
            REG_DEV_A:        regs.dev_a = val;
            REG_DEV_B:        regs.dev_b = val;
            REG_DEV_C:        regs.dev_c = val;
            REG_SPEED_RELOAD: regs.speed_reload = val;
            REG_OUT_MODULE:   regs.out_module = val;
            REG_OUT_ADDR:     regs.out_addr = val;
            default:          ;
        endcase
    endfunction

    function out_item_t make_result(logic [1:0] kind, logic [7:0] speed, logic [7:0] button);
        out_item_t r;
        r.kind           = kind;
        r.target_module  = regs.out_module;
        r.target_device  = regs.out_addr;
        r.speed_value    = speed;
        r.button_command = button;
        r.last           = 1'b0;
        return r;
    endfunction

    function out_item_t take_step(logic [1:0] kind);
        out_item_t r;
        r = make_result(kind, speed_cnt, 8'd0);
        speed_cnt = regs.speed_reload;
        return r;
    endfunction

    function void note_item(in_item_t it);
        out_item_t found[MAX_RES];
        int        n;
        logic      rising;
        n = 0;
        if (it.op)
        begin
            if (speed_cnt != 8'd0)
                speed_cnt--;
            return;
        end
        if (it.module_req != regs.in_module)
            return;
        rising = (it.event_code == RISING_CODE);
        if (it.device == regs.dev_a)
        begin
            if (last_seen == (rising ? EDGE_B_UP : EDGE_B_DOWN))
            begin
                found[n] = take_step(KIND_LEFT);
                n++;
            end
            last_seen = rising ? EDGE_A_UP : EDGE_A_DOWN;
        end
        if (it.device == regs.dev_b)
        begin
            if (last_seen == (rising ? EDGE_A_UP : EDGE_A_DOWN))
            begin
                found[n] = take_step(KIND_RIGHT);
                n++;
            end
            last_seen = rising ? EDGE_B_UP : EDGE_B_DOWN;
        end
        if (it.device == regs.dev_c)
        begin
            found[n] = make_result(KIND_BUTTON, 8'd0, {6'd0, it.event_code[3:2]} + BUTTON_BASE);
            n++;
        end
        if (n != 0)
            found[n-1].last = 1'b1;
        for (int i = 0; i < n; i++)
            expected_results.push_back(found[i]);
    endfunction

    function int pending();
        return expected_results.size();
    endfunction

    function void compare(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    function void check_result(out_item_t got);
        out_item_t want;
        if (expected_results.size() == 0)
        begin
            $error("result with nothing expected: %h", got);
            errors++;
            return;
        end
        want = expected_results.pop_front();
        compare("kind", 8'(want.kind), 8'(got.kind));
        compare("target_module", want.target_module, got.target_module);
        compare("target_device", want.target_device, got.target_device);
        compare("speed_value", want.speed_value, got.speed_value);
        compare("button_command", want.button_command, got.button_command);
        compare("last", 8'(want.last), 8'(got.last));
    endfunction
endclass

module tb_top;

    localparam logic [2:0] REG_NONE = 3'd7;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       item_valid;
    logic       item_stall;
    in_item_t   item;
    logic       result_valid;
    logic       result_stall;
    out_item_t  result;
    logic       cfg_we;
    logic [2:0] cfg_index;
    logic [7:0] cfg_data;

    red_scoreboard sb = new();
    cfg_t          cur_cfg;
    bit            calm;
    int            n_items;
    int            goal;

    rotary_encoder_step_decoder u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        result_stall <= !calm && ($urandom_range(0, 99) < 24);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
                sb.write_reg(cfg_index, cfg_data);
            if (item_valid && !item_stall)
                sb.note_item(item);
            if (result_valid && !result_stall)
                sb.check_result(result);
        end
    end

    function automatic logic [7:0] falling_code();
        logic [7:0] c;
        c = 8'($urandom);
        if (c == RISING_CODE)
            c = 8'h00;
        return c;
    endfunction

    function automatic in_item_t contact(logic [7:0] mod, logic [7:0] dev, logic [7:0] code);
        in_item_t it;
        it.op         = 1'b0;
        it.module_req = mod;
        it.device     = dev;
        it.event_code = code;
        return it;
    endfunction

    function automatic in_item_t tick();
        in_item_t it;
        it    = in_item_t'($urandom);
        it.op = 1'b1;
        return it;
    endfunction

    function automatic cfg_t random_cfg();
        cfg_t c;
        c.in_module    = 8'($urandom);
        c.dev_a        = 8'($urandom);
        c.dev_b        = ($urandom_range(0, 3) == 0) ? c.dev_a : 8'($urandom);
        c.dev_c        = ($urandom_range(0, 3) == 0) ? c.dev_b : 8'($urandom);
        c.speed_reload = $urandom_range(0, 1) ? 8'($urandom_range(0, 4)) : 8'($urandom);
        c.out_module   = 8'($urandom);
        c.out_addr     = 8'($urandom);
        return c;
    endfunction

    task automatic send_item(input in_item_t it);
        item       <= it;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (item_stall);
    endtask

    task automatic maybe_idle();
        if (!calm && $urandom_range(0, 99) < 24)
        begin
            item_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < 24);
        end
    endtask

    task automatic put(input in_item_t it);
        send_item(it);
        maybe_idle();
        n_items++;
    endtask

    task automatic settle();
        item_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    task automatic load_cfg(input cfg_t c);
        write_reg(REG_IN_MODULE, c.in_module);
        write_reg(REG_DEV_A, c.dev_a);
        write_reg(REG_DEV_B, c.dev_b);
        write_reg(REG_DEV_C, c.dev_c);
        write_reg(REG_SPEED_RELOAD, c.speed_reload);
        write_reg(REG_OUT_MODULE, c.out_module);
        write_reg(REG_OUT_ADDR, c.out_addr);
        cfg_we  <= 1'b0;
        cur_cfg = c;
    endtask

    // quadrature sequence, one step per edge pair
    task automatic turn(input bit clockwise, input int steps);
        logic [7:0] first_dev;
        logic [7:0] second_dev;
        bit         up;
        first_dev  = clockwise ? cur_cfg.dev_a : cur_cfg.dev_b;
        second_dev = clockwise ? cur_cfg.dev_b : cur_cfg.dev_a;
        up         = 1'($urandom_range(0, 1));
        for (int s = 0; s < steps; s++)
        begin
            put(contact(cur_cfg.in_module, first_dev, up ? RISING_CODE : falling_code()));
            if ($urandom_range(0, 9) < 3)
                put(tick());
            if ($urandom_range(0, 19) == 0)
                put(contact(cur_cfg.in_module, 8'($urandom), falling_code()));
            put(contact(cur_cfg.in_module, second_dev, up ? RISING_CODE : falling_code()));
            up = !up;
        end
    endtask

    initial
    begin
        #2_000_000;
        $display("tb_top: errors");
        $finish;
    end

    initial
    begin
        rst_n        <= 1'b0;
        item_valid   <= 1'b0;
        item         <= '0;
        cfg_we       <= 1'b0;
        cfg_index    <= '0;
        cfg_data     <= '0;
        calm         = 1'b0;
        n_items      = 0;
        cur_cfg      = sb.regs;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset defaults: counter held at zero, right step, button extremes
        put(tick());
        put(contact(8'h00, 8'h00, RISING_CODE));
        put(contact(8'h00, 8'h01, RISING_CODE));
        put(contact(8'h00, 8'h02, 8'hFF));
        put(contact(8'h00, 8'h02, 8'h00));

        settle();
        write_reg(REG_NONE, 8'hFF);
        load_cfg('{8'hFF, 8'h00, 8'hFF, 8'h80, 8'hFF, 8'hA5, 8'h5A});
        put(contact(8'hFF, 8'hFF, RISING_CODE));
        put(contact(8'hFF, 8'h00, RISING_CODE));
        put(tick());
        put(tick());
        put(contact(8'hFF, 8'h00, 8'h05));
        put(contact(8'hFF, 8'hFF, 8'h00));
        put(contact(8'hFF, 8'hFF, 8'hFB));
        put(contact(8'hFF, 8'h00, 8'h03));
        put(contact(8'h00, 8'h00, RISING_CODE));
        put({1'b1, 24'hFFFFFF});
        put(contact(8'hFF, 8'h80, 8'h0C));

        // one device number shared by all three contacts
        settle();
        load_cfg('{8'h3C, 8'h11, 8'h11, 8'h11, 8'h07, 8'h00, 8'hFF});
        put(contact(8'h3C, 8'h11, RISING_CODE));
        put(contact(8'h3C, 8'h11, RISING_CODE));
        put(contact(8'h3C, 8'h11, 8'h00));
        put(contact(8'h3C, 8'h11, 8'hF0));

        for (int p = 0; p < 5; p++)
        begin
            settle();
            case (p)
                0:       load_cfg('0);
                1:       load_cfg('1);
                default: load_cfg(random_cfg());
            endcase
            calm = (p == 2);
            goal = n_items + 92;
            while (n_items < goal)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5:
                        turn(1'($urandom_range(0, 1)), $urandom_range(1, 4));
                    6:
                        repeat ($urandom_range(1, 5)) put(tick());
                    7:
                        put(contact(cur_cfg.in_module, cur_cfg.dev_c, 8'($urandom)));
                    8:
                        put(in_item_t'($urandom));
                    default:
                        put(contact($urandom_range(0, 1) ? cur_cfg.in_module : 8'($urandom),
                                    $urandom_range(0, 1) ? cur_cfg.dev_a : 8'($urandom),
                                    $urandom_range(0, 1) ? RISING_CODE : falling_code()));
                endcase
            end
            calm = 1'b0;
        end

        settle();
        repeat (6) @(posedge clk);
        if (sb.errors == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
